### rtl/core/bcss_pkg.sv
// shared types and constants of the baud clock source selector
package bcss_pkg;

   // field widths
   localparam int FREQ_W     = 28;
   localparam int RATE_W     = 24;
   localparam int BAUD_W     = 16;
   localparam int WAIT_W     = 20;
   localparam int IDX_W      = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int NUM_REGS   = 3;

   // stream payload widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;

   // shared divider and multiplier datapath
   localparam int DIV_W      = 47;
   localparam int QUO_W      = 20;
   localparam int STEP_W     = 5;
   localparam int SCALED_W   = RATE_W + 20;
   localparam int PROD_W     = 45;
   localparam int MULB_W     = 17;
   localparam int BAUD_STEPS = 17;
   localparam int WAIT_STEPS = 20;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_FREQ_0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_FREQ_1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_FREQ_2 = 2'd2;

   localparam logic [WAIT_W-1:0] US_PER_SEC  = 20'd1000000;
   localparam logic [BAUD_W-1:0] BAUD_MAX    = 16'hFFFF;
   localparam logic [MULB_W-1:0] BAUD_FULL   = 17'h10000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_BDIV,
      ST_MUL,
      ST_CMP,
      ST_WDIV,
      ST_FINISH
   } state_type;

   // reset frequency of each source, sources past the register list stay at zero
   function automatic logic [FREQ_W-1:0] freq_reset(input int idx);
      logic [FREQ_W-1:0] val;
      case (idx)
         0:       val = 28'd100000000;
         1:       val = 28'd100000000;
         2:       val = 28'd120000000;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### rtl/core/baud_clock_source_selector_top.sv
// baud clock source selector: picks a clock source and arithmetic baud value per request
//
//   port group  dir  content
//   req_*       in   target rate request (stream)
//   rsp_*       out  selection result (stream)
//   csr_*       in   source frequency register writes
//
// each request checks the sources in turn; a source in range runs the baud division,
// the multiply and the compare, and a wait division follows when a source is found;
// the divisions use the shared shift-subtract divider, one quotient bit a cycle.
// reset is synchronous and restores the source frequencies and clears the stored rate.
// req_tready is high only between requests; a pending result does not stop a new
// request, and a finished request waits only for the result register to be free.
module baud_clock_source_selector_top #(
   parameter int NUM_SOURCES = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: target_rate [23:0]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bcss_pkg::REQ_DATA_W-1:0]   req_tdata,
   // result: source_index [1:0], baud_value [17:2], applied_rate [41:18],
   //         char_wait_us [61:42], zero fill [63:62]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bcss_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // result flag: ok [0]
   output logic                              rsp_tuser,
   // register writes
   input  logic                              csr_we,
   input  logic [bcss_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bcss_pkg::FREQ_W-1:0]       csr_wdata
);
   import bcss_pkg::*;

   localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
   localparam logic [SRC_W-1:0] LAST_SRC = SRC_W'(NUM_SOURCES - 1);

   // source frequency registers
   logic [FREQ_W-1:0] freq_ff [NUM_SOURCES];

   for (genvar g = 0; g < NUM_SOURCES; g++) begin : g_src
      always_ff @(posedge clock) begin
         if (reset) begin
            freq_ff[g] <= freq_reset(g);
         end else if (csr_we && (g < NUM_REGS) && (csr_index == CSR_IDX_W'(g))) begin
            freq_ff[g] <= csr_wdata;
         end
      end
   end

   // control and state registers
   state_type           state_ff, state_in;
   logic [SRC_W-1:0]    src_ff, src_in;
   logic                found_ff, found_in;
   logic [RATE_W-1:0]   cur_rate_ff, cur_rate_in;
   logic [WAIT_W-1:0]   cur_wait_ff, cur_wait_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    dsr_ff, dsr_in;
   logic [QUO_W-1:0]    quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [BAUD_W-1:0]   baud_ff, baud_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [PROD_W-1:0]   best_err_ff, best_err_in;
   logic [BAUD_W-1:0]   best_baud_ff, best_baud_in;
   logic [SRC_W-1:0]    best_idx_ff, best_idx_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [IDX_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [BAUD_W-1:0]   rsp_baud_ff, rsp_baud_in;
   logic [RATE_W-1:0]   rsp_rate_ff, rsp_rate_in;
   logic [WAIT_W-1:0]   rsp_wait_ff, rsp_wait_in;

   // range check and divider load values for the current source
   logic [FREQ_W-1:0]   cur_freq;
   logic [SCALED_W-1:0] scaled;
   logic [SCALED_W-1:0] freq_sh;
   logic [SCALED_W-1:0] hi_full;
   logic [RATE_W-1:0]   lo_rate;
   logic [RATE_W-1:0]   hi_rate;
   logic                in_range;
   logic [SCALED_W-1:0] num;

   assign cur_freq = freq_ff[src_ff];
   assign scaled   = {rate_ff, 20'b0};
   assign freq_sh  = {cur_freq, 16'b0};
   assign hi_full  = freq_sh - SCALED_W'(cur_freq);
   assign lo_rate  = RATE_W'(cur_freq >> 20);
   assign hi_rate  = RATE_W'(hi_full >> 20);
   assign in_range = (rate_ff != '0) && (rate_ff >= lo_rate) && (rate_ff <= hi_rate);
   assign num      = freq_sh - scaled;

   // shared shift-subtract divider step
   logic                div_ge;
   logic [DIV_W-1:0]    div_rem;
   logic [QUO_W-1:0]    div_quo;

   assign div_ge  = (rem_ff >= dsr_ff);
   assign div_rem = div_ge ? (rem_ff - dsr_ff) : rem_ff;
   assign div_quo = {quo_ff[QUO_W-2:0], div_ge};

   // saturated baud value and multiplier operand
   logic [BAUD_W-1:0]   baud_sat;
   logic [MULB_W-1:0]   mul_b;

   assign baud_sat = (quo_ff[QUO_W-1:BAUD_W] != '0) ? BAUD_MAX : quo_ff[BAUD_W-1:0];
   assign mul_b    = BAUD_FULL - MULB_W'(baud_sat);

   // error of the achieved rate against the target
   logic [PROD_W-1:0]   scaled_ext;
   logic [PROD_W-1:0]   err;
   logic                better;

   assign scaled_ext = PROD_W'(scaled);
   assign err        = (prod_ff >= scaled_ext) ? (prod_ff - scaled_ext)
                                               : (scaled_ext - prod_ff);
   assign better     = !found_ff || (err < best_err_ff);

   // sequencer: next state and datapath loads
   logic advance;
   logic found_now;

   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      found_in     = found_ff;
      cur_rate_in  = cur_rate_ff;
      cur_wait_in  = cur_wait_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rate_in      = rate_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      baud_in      = baud_ff;
      prod_in      = prod_ff;
      best_err_in  = best_err_ff;
      best_baud_in = best_baud_ff;
      best_idx_in  = best_idx_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_baud_in  = rsp_baud_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_wait_in  = rsp_wait_ff;
      advance      = 1'b0;
      found_now    = found_ff;
      req_tready   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rate_in  = req_tdata[RATE_W-1:0];
               src_in   = '0;
               found_in = 1'b0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (in_range) begin
               rem_in   = DIV_W'({num, 1'b0}) + DIV_W'(cur_freq);
               dsr_in   = DIV_W'({cur_freq, 17'b0});
               quo_in   = '0;
               step_in  = STEP_W'(BAUD_STEPS);
               state_in = ST_BDIV;
            end else begin
               advance = 1'b1;
            end
         end
         ST_BDIV: begin
            rem_in  = div_rem;
            dsr_in  = dsr_ff >> 1;
            quo_in  = div_quo;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            baud_in  = baud_sat;
            prod_in  = PROD_W'(cur_freq) * PROD_W'(mul_b);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            found_now = 1'b1;
            found_in  = 1'b1;
            if (better) begin
               best_err_in  = err;
               best_baud_in = baud_ff;
               best_idx_in  = src_ff;
            end
            advance = 1'b1;
         end
         ST_WDIV: begin
            rem_in  = div_rem;
            dsr_in  = dsr_ff >> 1;
            quo_in  = div_quo;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               cur_rate_in = rate_ff;
               cur_wait_in = div_quo[WAIT_W-1:0];
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = found_ff;
               rsp_idx_in   = found_ff ? IDX_W'(best_idx_ff) : '0;
               rsp_baud_in  = found_ff ? best_baud_ff : '0;
               rsp_rate_in  = cur_rate_ff;
               rsp_wait_in  = cur_wait_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // next source, or after the last: wait division if one was found, else finish
      if (advance) begin
         if (src_ff == LAST_SRC) begin
            if (found_now) begin
               rem_in   = DIV_W'(US_PER_SEC);
               dsr_in   = DIV_W'({rate_ff, 19'b0});
               quo_in   = '0;
               step_in  = STEP_W'(WAIT_STEPS);
               state_in = ST_WDIV;
            end else begin
               state_in = ST_FINISH;
            end
         end else begin
            src_in   = src_ff + SRC_W'(1);
            state_in = ST_CHECK;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_ff       <= '0;
         found_ff     <= 1'b0;
         cur_rate_ff  <= '0;
         cur_wait_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_ff       <= src_in;
         found_ff     <= found_in;
         cur_rate_ff  <= cur_rate_in;
         cur_wait_ff  <= cur_wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rate_ff      <= rate_in;
      rem_ff       <= rem_in;
      dsr_ff       <= dsr_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      baud_ff      <= baud_in;
      prod_ff      <= prod_in;
      best_err_ff  <= best_err_in;
      best_baud_ff <= best_baud_in;
      best_idx_ff  <= best_idx_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_baud_ff  <= rsp_baud_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_wait_ff  <= rsp_wait_in;
   end

   // result ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {2'b00, rsp_wait_ff, rsp_rate_ff, rsp_baud_ff, rsp_idx_ff};

   // divider never runs with an exhausted step count
   a_div_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BDIV || state_ff == ST_WDIV) |-> (step_ff != '0))
      else $error("divider running with zero steps left");

   // failed request reports zero source and baud value
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[17:0] == '0))
      else $error("failed result carries a source or baud value");

   // successful request always leaves a nonzero rate in force
   a_ok_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[41:18] != '0))
      else $error("successful result with zero applied rate");

   // chosen source lies within the configured sources
   a_best_idx: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (best_idx_ff <= LAST_SRC))
      else $error("best source index out of range");

   // stored rate changes only at the end of the wait division or on reset
   a_rate_update: assert property (@(posedge clock) disable iff (reset)
      (cur_rate_ff != $past(cur_rate_ff)) |-> ($past(state_ff) == ST_WDIV || $past(reset)))
      else $error("stored rate changed outside the wait division");

endmodule
